/* sv/mcfr_pkg.sv */
// ----------------------------------------------------------------------------
// Motion command frame receiver package
// Shared types, constants and helper functions for the frame receiver.
// ----------------------------------------------------------------------------
package mcfr_pkg;

  // Frame marker bytes.
  localparam logic [7:0] START_BYTE = 8'hFF;
  localparam logic [7:0] HEAD1_BYTE = 8'hFE;
  localparam logic [7:0] HEAD2_BYTE = 8'h01;
  localparam logic [7:0] TAIL_BYTE  = 8'h00;

  // Register reset values.
  localparam logic [15:0] TIMEOUT_TICKS_RESET  = 16'd1000;
  localparam logic        TIMEOUT_ENABLE_RESET = 1'b1;

  // Result queue depth default.
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  // Register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TIMEOUT_TICKS  = 1'b0,
    REG_TIMEOUT_ENABLE = 1'b1
  } reg_index_t;

  // Input item kinds carried in tuser.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result sources carried in tuser.
  localparam logic SRC_FRAME   = 1'b0;
  localparam logic SRC_TIMEOUT = 1'b1;

  // Configuration register set.
  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic        timeout_enable;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic               source;
    logic signed [15:0] r_speed;
    logic signed [15:0] x_speed;
    logic signed [15:0] y_speed;
  } result_t;

  // Two's complement negation that maps the most negative value to the most
  // positive one.
  function automatic logic [15:0] negate_sat(input logic [15:0] v);
    logic [15:0] neg;
    neg = 16'd0 - v;
    if (v == 16'h8000) begin
      neg = 16'h7FFF;
    end
    return neg;
  endfunction

endpackage

/* sv/motion_command_frame_receiver.sv */
// ----------------------------------------------------------------------------
// Motion command frame receiver
// Collects serial frames into y, x and rotation speed commands and, when the
// timeout is enabled, issues a zero command when no valid frame arrives within the tick timeout.
// ----------------------------------------------------------------------------
// A result passes through the input register and then the result queue before it can be taken.
// Throughput: one request per cycle while the result queue has room, set by the single input register stage.
// Output stalls are absorbed by a QUEUE_DEPTH entry result queue.
// Reset: synchronous, clears the frame state, tick count and queue and loads
// the timeout registers with 1000 ticks, enabled.
// ----------------------------------------------------------------------------
module motion_command_frame_receiver #(
  parameter int QUEUE_DEPTH = mcfr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mcfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mcfr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // rx_byte
  input  logic                             s_axis_tuser,  // operation
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [47:0]                      m_axis_tdata,  // y_speed, x_speed, r_speed
  output logic                             m_axis_tuser   // source
);
  import mcfr_pkg::*;

  cfg_t    cfg;
  logic    in_valid;
  logic    pipe_valid;
  logic    res_push;
  result_t res;
  result_t out_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks  <= TIMEOUT_TICKS_RESET;
      cfg.timeout_enable <= TIMEOUT_ENABLE_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_TIMEOUT_TICKS:  cfg.timeout_ticks  <= cfg_wdata[15:0];
        REG_TIMEOUT_ENABLE: cfg.timeout_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_valid = s_axis_tvalid & s_axis_tready;

  // Frame collection and timeout.
  mcfr_core u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_op      (s_axis_tuser),
    .in_byte    (s_axis_tdata),
    .cfg        (cfg),
    .pipe_valid (pipe_valid),
    .res_push   (res_push),
    .res        (res)
  );

  // Result buffering.
  mcfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res),
    .pop       (m_axis_tvalid & m_axis_tready),
    .pending   (pipe_valid),
    .accept_ok (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (out_data)
  );

  // Output packing, y speed in the lowest bits.
  assign m_axis_tdata = {out_data.r_speed, out_data.x_speed, out_data.y_speed};
  assign m_axis_tuser = out_data.source;

endmodule

/* sv/mcfr_core.sv */
// ----------------------------------------------------------------------------
// Frame receiver core
// Input register, frame collection, header and tail checks, and the tick
// timeout counter. Produces at most one result per registered input item.
// ----------------------------------------------------------------------------
module mcfr_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_op,
  input  logic [7:0]       in_byte,
  input  mcfr_pkg::cfg_t   cfg,
  output logic             pipe_valid,
  output logic             res_push,
  output mcfr_pkg::result_t res
);
  import mcfr_pkg::*;

  // Byte positions within a frame.
  localparam logic [3:0] POS_IDLE  = 4'd0;
  localparam logic [3:0] POS_HEAD1 = 4'd1;
  localparam logic [3:0] POS_HEAD2 = 4'd2;
  localparam logic [3:0] POS_Y_LO  = 4'd3;
  localparam logic [3:0] POS_Y_HI  = 4'd4;
  localparam logic [3:0] POS_X_LO  = 4'd5;
  localparam logic [3:0] POS_X_HI  = 4'd6;
  localparam logic [3:0] POS_R_LO  = 4'd7;
  localparam logic [3:0] POS_R_HI  = 4'd8;
  localparam logic [3:0] POS_TAIL  = 4'd9;

  logic        pipe_op;
  logic [7:0]  pipe_byte;

  logic [3:0]  byte_position, byte_position_next;
  logic        header_ok, header_ok_next;
  logic [7:0]  y_low_byte, y_low_byte_next;
  logic [15:0] partial_y, partial_y_next;
  logic [15:0] partial_x, partial_x_next;
  logic [15:0] partial_r, partial_r_next;
  logic [15:0] elapsed_ticks, elapsed_ticks_next;
  logic [15:0] elapsed_inc;

  // Input register: one accepted request per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else begin
      pipe_valid <= in_valid;
    end
    if (in_valid) begin
      pipe_op   <= in_op;
      pipe_byte <= in_byte;
    end
  end

  // Frame and timeout logic on the registered request.
  always_comb begin
    byte_position_next = byte_position;
    header_ok_next     = header_ok;
    y_low_byte_next    = y_low_byte;
    partial_y_next     = partial_y;
    partial_x_next     = partial_x;
    partial_r_next     = partial_r;
    elapsed_ticks_next = elapsed_ticks;
    res_push           = 1'b0;
    res.source         = SRC_FRAME;
    res.y_speed        = partial_y;
    res.x_speed        = partial_x;
    res.r_speed        = negate_sat(partial_r);

    elapsed_inc = (elapsed_ticks == 16'hFFFF) ? elapsed_ticks : elapsed_ticks + 16'd1;

    if (pipe_valid) begin
      if (pipe_op == OP_TICK) begin
        // Tick: count up, then fire a zero command on timeout.
        elapsed_ticks_next = elapsed_inc;
        if (cfg.timeout_enable && (elapsed_inc >= cfg.timeout_ticks)) begin
          elapsed_ticks_next = 16'd0;
          res_push           = 1'b1;
          res.source         = SRC_TIMEOUT;
          res.y_speed        = 16'sd0;
          res.x_speed        = 16'sd0;
          res.r_speed        = 16'sd0;
        end
      end else begin
        byte_position_next = byte_position + 4'd1;
        case (byte_position)
          POS_IDLE: begin
            byte_position_next = (pipe_byte == START_BYTE) ? POS_HEAD1 : POS_IDLE;
          end
          POS_HEAD1: header_ok_next  = (pipe_byte == HEAD1_BYTE);
          POS_HEAD2: header_ok_next  = header_ok && (pipe_byte == HEAD2_BYTE);
          POS_Y_LO:  y_low_byte_next = pipe_byte;
          POS_Y_HI:  partial_y_next  = {pipe_byte, y_low_byte};
          POS_X_LO:  partial_x_next  = {8'd0, pipe_byte};
          POS_X_HI:  partial_x_next  = {pipe_byte, partial_x[7:0]};
          POS_R_LO:  partial_r_next  = {8'd0, pipe_byte};
          POS_R_HI:  partial_r_next  = {pipe_byte, partial_r[7:0]};
          POS_TAIL: begin
            byte_position_next = POS_IDLE;
            if (header_ok && (pipe_byte == TAIL_BYTE)) begin
              elapsed_ticks_next = 16'd0;
              res_push           = 1'b1;
            end
          end
          default: byte_position_next = POS_IDLE;
        endcase
      end
    end
  end

  // Receiver state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_IDLE;
      header_ok     <= 1'b0;
      y_low_byte    <= 8'd0;
      partial_y     <= 16'd0;
      partial_x     <= 16'd0;
      partial_r     <= 16'd0;
      elapsed_ticks <= 16'd0;
    end else begin
      byte_position <= byte_position_next;
      header_ok     <= header_ok_next;
      y_low_byte    <= y_low_byte_next;
      partial_y     <= partial_y_next;
      partial_x     <= partial_x_next;
      partial_r     <= partial_r_next;
      elapsed_ticks <= elapsed_ticks_next;
    end
  end

endmodule

/* sv/mcfr_queue.sv */
// ----------------------------------------------------------------------------
// Frame receiver result queue
// Small result buffer that decouples the input side from output stalls.
// Reserves room for the request still held in the input register.
// ----------------------------------------------------------------------------
module mcfr_queue #(
  parameter int DEPTH = mcfr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mcfr_pkg::result_t push_data,
  input  logic              pop,
  input  logic              pending,
  output logic              accept_ok,
  output logic              out_valid,
  output mcfr_pkg::result_t out_data
);
  import mcfr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t            mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic [CNT_W:0]     committed;

  // Room is needed for the new request and for the one in the input register.
  assign committed = {1'b0, count} + {{CNT_W{1'b0}}, pending};
  assign accept_ok = committed < (CNT_W + 1)'(DEPTH);
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];

  // Pointer and fill tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

/* sv/mcfr_checker.sv */
// ----------------------------------------------------------------------------
// Frame receiver port checker
// Checks the result stream of the frame receiver as seen on its ports.
// ----------------------------------------------------------------------------
module mcfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  import mcfr_pkg::*;

  // A stalled result stays offered.
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result request dropped while stalled");

  // A stalled result keeps its payload.
  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result payload changed while stalled");

  // A timeout result is a zero command.
  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == SRC_TIMEOUT) |-> m_axis_tdata == 48'd0)
    else $error("timeout result carries nonzero speed");

  // Negated rotation never yields the most negative value.
  a_rot_sat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == SRC_FRAME) |-> m_axis_tdata[47:32] != 16'h8000)
    else $error("rotation negation not saturated");

  // The result queue is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result offered right after reset");

endmodule

bind motion_command_frame_receiver mcfr_checker u_mcfr_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
